[hdl/bptc_pkg.sv]
// shared widths, register indexes and limits of the barometer compensation block
package bptc_pkg;

  localparam int unsigned RAW_W     = 24;
  localparam int unsigned CAL_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CAL   = 6;
  localparam int unsigned TEMP_W    = 19;
  localparam int unsigned PRES_W    = 20;

  // calibration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_AT_REF      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_AT_REF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMP_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMP_COEF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMPERATURE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SENS_COEF   = 3'd5;

  localparam logic [PRES_W-1:0] PRES_MAX = {PRES_W{1'b1}};

  typedef logic [CAL_W-1:0] cal_t;

endpackage

[hdl/bptc_ifs.sv]
// valid/ready channel interfaces for raw samples and compensated results
interface bptc_in_if;
  logic                         valid;
  logic                         ready;
  logic [bptc_pkg::RAW_W-1:0]   raw_pressure;
  logic [bptc_pkg::RAW_W-1:0]   raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bptc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [bptc_pkg::TEMP_W-1:0] temperature_centi;
  logic [bptc_pkg::PRES_W-1:0]        pressure_centi;
  logic                               pressure_clipped;

  modport source (output valid, output temperature_centi, output pressure_centi,
                  output pressure_clipped, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_centi,
                  input pressure_clipped, output ready);
endinterface

[hdl/barometer_pressure_temp_compensation_top.sv]
// Barometer second-order temperature compensation, twelve-stage pipeline.
// One raw pressure/temperature pair is taken per clock while the input is
// ready; the pipeline keeps a valid bit per stage. A stalled output only holds
// the stages that are full: empty stages keep filling, so the input stays ready
// until all twelve stages hold a sample. The six calibration words are written
// through the plain write port; the user must write them only while no sample
// is in flight, which the block itself does not enforce. Indexes above five are
// ignored. Wide products are split: the final pressure product is formed from
// two 24x20 partial products summed in the next stage.
module barometer_pressure_temp_compensation_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bptc_pkg::CAL_W-1:0]         cfg_data_i,
  bptc_in_if.sink                            in_i,
  bptc_out_if.source                         out_o
);

  localparam int unsigned NST = 12;

  // calibration registers
  bptc_pkg::cal_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bptc_pkg::CFG_SENS_AT_REF:      c1_q <= cfg_data_i;
        bptc_pkg::CFG_OFFSET_AT_REF:    c2_q <= cfg_data_i;
        bptc_pkg::CFG_SENS_TEMP_COEF:   c3_q <= cfg_data_i;
        bptc_pkg::CFG_OFFSET_TEMP_COEF: c4_q <= cfg_data_i;
        bptc_pkg::CFG_REF_TEMPERATURE:  c5_q <= cfg_data_i;
        bptc_pkg::CFG_TEMP_SENS_COEF:   c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits and per-stage load enables (bubbles collapse)
  logic [NST:1]   v_q;
  logic [NST:1]   v_in;
  logic [NST+1:1] en;
  logic [NST:1]   hold;

  always_comb begin
    en[NST+1] = out_o.ready;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NST-1:1], in_i.valid};
  assign hold = v_q & ~en[NST+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign in_i.ready = en[1];

  // stage 1: dT
  logic signed [24:0] s1_dt_q, s1_dt_d;
  logic [23:0]        s1_d1_q;

  assign s1_dt_d = $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, c5_q, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= in_i.raw_pressure;
    end
  end

  // stage 2: products of dT
  logic signed [41:0] s2_tprod_q, s2_oprod_q, s2_sprod_q;
  logic signed [41:0] tprod_d, oprod_d, sprod_d;
  logic signed [49:0] dtsq_d;
  logic [47:0]        s2_dtsq_q;
  logic [23:0]        s2_d1_q;

  assign tprod_d = s1_dt_q * $signed({1'b0, c6_q});
  assign oprod_d = s1_dt_q * $signed({1'b0, c4_q});
  assign sprod_d = s1_dt_q * $signed({1'b0, c3_q});
  assign dtsq_d  = s1_dt_q * s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_tprod_q <= tprod_d;
      s2_oprod_q <= oprod_d;
      s2_sprod_q <= sprod_d;
      s2_dtsq_q  <= dtsq_d[47:0];
      s2_d1_q    <= s1_d1_q;
    end
  end

  // stage 3: truncating shifts, first-order temp, OFF, SENS
  logic signed [41:0] tb_d, ob_d, sb_d;
  logic signed [18:0] q_d, b_d;
  logic signed [34:0] off_d;
  logic signed [33:0] sens_d;
  logic signed [18:0] s3_q_q, s3_b_q;
  logic signed [34:0] s3_off_q;
  logic signed [33:0] s3_sens_q;
  logic [16:0]        s3_t2_q;
  logic [23:0]        s3_d1_q;

  always_comb begin
    tb_d   = s2_tprod_q + (s2_tprod_q[41] ? 42'sd8388607 : 42'sd0);
    ob_d   = s2_oprod_q + (s2_oprod_q[41] ? 42'sd127 : 42'sd0);
    sb_d   = s2_sprod_q + (s2_sprod_q[41] ? 42'sd255 : 42'sd0);
    // q is TEMP - 2000
    q_d    = tb_d[41:23];
    b_d    = q_d + 19'sd3500;
    off_d  = $signed({3'b000, c2_q, 16'h0000}) + $signed(ob_d[41:7]);
    sens_d = $signed({3'b000, c1_q, 15'h0000}) + $signed(sb_d[41:8]);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_q_q    <= q_d;
      s3_b_q    <= b_d;
      s3_off_q  <= off_d;
      s3_sens_q <= sens_d;
      s3_t2_q   <= s2_dtsq_q[47:31];
      s3_d1_q   <= s2_d1_q;
    end
  end

  // stage 4: squares and range flags
  logic signed [37:0] sqa_d, sqb_d;
  logic [33:0]        s4_sq_q, s4_sq2_q;
  logic               s4_lt20_q, s4_ltm15_q;
  logic signed [18:0] s4_q_q;
  logic signed [34:0] s4_off_q;
  logic signed [33:0] s4_sens_q;
  logic [16:0]        s4_t2_q;
  logic [23:0]        s4_d1_q;

  assign sqa_d = s3_q_q * s3_q_q;
  assign sqb_d = s3_b_q * s3_b_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_sq_q    <= sqa_d[33:0];
      s4_sq2_q   <= sqb_d[33:0];
      s4_lt20_q  <= s3_q_q[18];
      s4_ltm15_q <= s3_q_q < -19'sd3500;
      s4_q_q     <= s3_q_q;
      s4_off_q   <= s3_off_q;
      s4_sens_q  <= s3_sens_q;
      s4_t2_q    <= s3_t2_q;
      s4_d1_q    <= s3_d1_q;
    end
  end

  // stage 5: scaled squares, gated by the low-temperature flags
  logic [37:0]        sq2x8_d;
  logic [36:0]        sq5_d, sq7_d;
  logic [37:0]        sq11_d;
  logic [36:0]        s5_sq5_q, s5_sq7_q;
  logic [37:0]        s5_sq11_q;
  logic [16:0]        s5_t2_q;
  logic signed [18:0] s5_q_q;
  logic signed [34:0] s5_off_q;
  logic signed [33:0] s5_sens_q;
  logic [23:0]        s5_d1_q;

  always_comb begin
    sq2x8_d = {1'b0, s4_sq2_q, 3'b000};
    sq5_d   = {1'b0, s4_sq_q, 2'b00} + {3'b000, s4_sq_q};
    sq7_d   = 37'(sq2x8_d - {4'h0, s4_sq2_q});
    sq11_d  = sq2x8_d + {3'b000, s4_sq2_q, 1'b0} + {4'h0, s4_sq2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_sq5_q  <= s4_lt20_q ? sq5_d : '0;
      s5_sq7_q  <= s4_ltm15_q ? sq7_d : '0;
      s5_sq11_q <= s4_ltm15_q ? sq11_d : '0;
      s5_t2_q   <= s4_lt20_q ? s4_t2_q : '0;
      s5_q_q    <= s4_q_q;
      s5_off_q  <= s4_off_q;
      s5_sens_q <= s4_sens_q;
      s5_d1_q   <= s4_d1_q;
    end
  end

  // stage 6: OFF2, SENS2, output temperature
  logic [37:0]        off2_d, sens2_d;
  logic signed [19:0] tout_d;
  logic [37:0]        s6_off2_q, s6_sens2_q;
  logic signed [18:0] s6_tout_q;
  logic signed [34:0] s6_off_q;
  logic signed [33:0] s6_sens_q;
  logic [23:0]        s6_d1_q;

  always_comb begin
    off2_d  = {2'b00, s5_sq5_q[36:1]} + {1'b0, s5_sq7_q};
    sens2_d = {3'b000, s5_sq5_q[36:2]} + {1'b0, s5_sq11_q[37:1]};
    tout_d  = {s5_q_q[18], s5_q_q} + 20'sd2000 - $signed({3'b000, s5_t2_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_off2_q  <= off2_d;
      s6_sens2_q <= sens2_d;
      s6_tout_q  <= tout_d[18:0];
      s6_off_q   <= s5_off_q;
      s6_sens_q  <= s5_sens_q;
      s6_d1_q    <= s5_d1_q;
    end
  end

  // stage 7: corrected OFF and SENS
  logic signed [39:0] offc_d, sensc_d;
  logic signed [39:0] s7_offc_q, s7_sensc_q;
  logic signed [18:0] s7_tout_q;
  logic [23:0]        s7_d1_q;

  always_comb begin
    offc_d  = {{5{s6_off_q[34]}}, s6_off_q} - $signed({2'b00, s6_off2_q});
    sensc_d = {{6{s6_sens_q[33]}}, s6_sens_q} - $signed({2'b00, s6_sens2_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_offc_q  <= offc_d;
      s7_sensc_q <= sensc_d;
      s7_tout_q  <= s6_tout_q;
      s7_d1_q    <= s6_d1_q;
    end
  end

  // stage 8: D1 * SENS as two partial products
  logic [43:0]        lo_d;
  logic signed [44:0] hi_d;
  logic [43:0]        s8_lo_q;
  logic signed [44:0] s8_hi_q;
  logic signed [39:0] s8_offc_q;
  logic signed [18:0] s8_tout_q;

  assign lo_d = s7_d1_q * s7_sensc_q[19:0];
  assign hi_d = $signed({1'b0, s7_d1_q}) * $signed(s7_sensc_q[39:20]);

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_lo_q   <= lo_d;
      s8_hi_q   <= hi_d;
      s8_offc_q <= s7_offc_q;
      s8_tout_q <= s7_tout_q;
    end
  end

  // stage 9: partial product sum
  logic signed [63:0] prod_d;
  logic signed [63:0] s9_prod_q;
  logic signed [39:0] s9_offc_q;
  logic signed [18:0] s9_tout_q;

  // hi fits 44 bits, its top bit is sign extension only
  assign prod_d = $signed({s8_hi_q[43:0], 20'h00000}) + $signed({20'h00000, s8_lo_q});

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_prod_q <= prod_d;
      s9_offc_q <= s8_offc_q;
      s9_tout_q <= s8_tout_q;
    end
  end

  // stage 10: truncate toward zero by 2^21
  logic signed [63:0] pb_d;
  logic signed [42:0] s10_q1_q;
  logic signed [39:0] s10_offc_q;
  logic signed [18:0] s10_tout_q;

  assign pb_d = s9_prod_q + (s9_prod_q[63] ? 64'sd2097151 : 64'sd0);

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s10_q1_q   <= pb_d[63:21];
      s10_offc_q <= s9_offc_q;
      s10_tout_q <= s9_tout_q;
    end
  end

  // stage 11: subtract OFF
  logic signed [42:0] r_d;
  logic signed [42:0] s11_r_q;
  logic signed [18:0] s11_tout_q;

  assign r_d = s10_q1_q - {{3{s10_offc_q[39]}}, s10_offc_q};

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      s11_r_q    <= r_d;
      s11_tout_q <= s10_tout_q;
    end
  end

  // stage 12: truncate by 2^15 and saturate into the output register
  logic signed [42:0] rb_d;
  logic signed [27:0] p_d;
  logic               p_neg, p_over;
  logic [19:0]        pres_d;
  logic [19:0]        s12_pres_q;
  logic               s12_clip_q;
  logic signed [18:0] s12_tout_q;

  always_comb begin
    rb_d   = s11_r_q + (s11_r_q[42] ? 43'sd32767 : 43'sd0);
    p_d    = rb_d[42:15];
    p_neg  = p_d[27];
    p_over = !p_d[27] && (|p_d[26:20]);
    if (p_neg) begin
      pres_d = '0;
    end else if (p_over) begin
      pres_d = bptc_pkg::PRES_MAX;
    end else begin
      pres_d = p_d[19:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      s12_pres_q <= pres_d;
      s12_clip_q <= p_neg || p_over;
      s12_tout_q <= s11_tout_q;
    end
  end

  assign out_o.valid             = v_q[NST];
  assign out_o.temperature_centi = s12_tout_q;
  assign out_o.pressure_centi    = s12_pres_q;
  assign out_o.pressure_clipped  = s12_clip_q;

`ifndef ASSERT_OFF
  // a transfer in always lands in the first stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[1])
    else $error("accepted sample not captured in stage 1");

  // a stage blocked downstream keeps its sample
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((v_q & $past(hold)) == $past(hold)))
    else $error("stalled stage lost its sample");

  // input stalls only when every stage is full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&v_q))
    else $error("input stalled with an empty stage");

  // a clipped pressure sits at one end of its range
  a_clip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.pressure_clipped |->
      (out_o.pressure_centi == '0) || (out_o.pressure_centi == bptc_pkg::PRES_MAX))
    else $error("clipped pressure not at a range limit");
`endif

endmodule

[tb/testbench.sv]
// self-checking testbench for the barometer second-order temperature compensation block
module testbench;

  localparam int RESET_CYCLES    = 9;
  localparam int DRAIN_SLACK     = 16;
  localparam int RANDOM_PHASES   = 8;
  localparam int SAMPLES_PER_SET = 170;
  localparam int TIMEOUT_TICKS   = 20 * 400_000;

  localparam longint SCALE_2_7  = 64'sd128;
  localparam longint SCALE_2_8  = 64'sd256;
  localparam longint SCALE_2_15 = 64'sd32768;
  localparam longint SCALE_2_16 = 64'sd65536;
  localparam longint SCALE_2_21 = 64'sd2097152;
  localparam longint SCALE_2_23 = 64'sd8388608;
  localparam longint SCALE_2_31 = 64'sd2147483648;

  localparam longint TEMP_REF_CENTI = 64'sd2000;
  localparam longint VERY_LOW_CENTI = -64'sd1500;

  typedef logic [bptc_pkg::RAW_W-1:0]     raw_word_t;
  typedef logic [bptc_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_UNUSED_LO = 3'd6;
  localparam cfg_idx_t CFG_UNUSED_HI = 3'd7;

  localparam raw_word_t TYPICAL_D1 = 24'd9085466;
  localparam raw_word_t TYPICAL_D2 = 24'd8569150;
  localparam bptc_pkg::cal_t TYPICAL_CAL [bptc_pkg::NUM_CAL] =
    '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    raw_word_t raw_p;
    raw_word_t raw_t;
  } sample_t;

  typedef struct {
    logic signed [bptc_pkg::TEMP_W-1:0] temp_centi;
    logic [bptc_pkg::PRES_W-1:0]        pres_centi;
    logic                               clipped;
  } reading_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we;
  cfg_idx_t       cfg_idx;
  bptc_pkg::cal_t cfg_data;

  bptc_in_if  in_bus ();
  bptc_out_if out_bus ();

  barometer_pressure_temp_compensation_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  sample_t        pending_samples[$];
  reading_t       expected_readings[$];
  bptc_pkg::cal_t cal_words [bptc_pkg::NUM_CAL];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned checked_count;
  int unsigned clipped_count;
  int unsigned cold_count;
  int unsigned very_cold_count;
  sample_t     next_sample;
  reading_t    want;

  // exact integer compensation, every division truncating toward zero
  function automatic reading_t compensate(input raw_word_t raw_p,
                                          input raw_word_t raw_t);
    longint c1, c2, c3, c4, c5, c6;
    longint d1, d2, dt, temp, off, sens, t2, off2, sens2, dev, dev2, p, tout;
    reading_t r;
    c1 = longint'(cal_words[bptc_pkg::CFG_SENS_AT_REF]);
    c2 = longint'(cal_words[bptc_pkg::CFG_OFFSET_AT_REF]);
    c3 = longint'(cal_words[bptc_pkg::CFG_SENS_TEMP_COEF]);
    c4 = longint'(cal_words[bptc_pkg::CFG_OFFSET_TEMP_COEF]);
    c5 = longint'(cal_words[bptc_pkg::CFG_REF_TEMPERATURE]);
    c6 = longint'(cal_words[bptc_pkg::CFG_TEMP_SENS_COEF]);
    d1 = longint'(raw_p);
    d2 = longint'(raw_t);
    dt   = d2 - c5 * SCALE_2_8;
    temp = TEMP_REF_CENTI + (dt * c6) / SCALE_2_23;
    off  = c2 * SCALE_2_16 + (c4 * dt) / SCALE_2_7;
    sens = c1 * SCALE_2_15 + (c3 * dt) / SCALE_2_8;
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    if (temp < TEMP_REF_CENTI) begin
      dev   = (temp - TEMP_REF_CENTI) * (temp - TEMP_REF_CENTI);
      t2    = (dt * dt) / SCALE_2_31;
      off2  = (5 * dev) / 2;
      sens2 = (5 * dev) / 4;
      if (temp < VERY_LOW_CENTI) begin
        dev2  = (temp - VERY_LOW_CENTI) * (temp - VERY_LOW_CENTI);
        off2  = off2 + 7 * dev2;
        sens2 = sens2 + (11 * dev2) / 2;
      end
    end
    off  = off - off2;
    sens = sens - sens2;
    p = ((d1 * sens) / SCALE_2_21 - off) / SCALE_2_15;
    r.clipped = 1'b0;
    if (p < 0) begin
      p = 0;
      r.clipped = 1'b1;
    end else if (p > longint'(bptc_pkg::PRES_MAX)) begin
      p = longint'(bptc_pkg::PRES_MAX);
      r.clipped = 1'b1;
    end
    tout = temp - t2;
    r.temp_centi = tout[bptc_pkg::TEMP_W-1:0];
    r.pres_centi = p[bptc_pkg::PRES_W-1:0];
    return r;
  endfunction

  // raw temperature that lands next to a first-order temperature target
  function automatic raw_word_t raw_temp_near(input longint target_centi,
                                              input longint jitter);
    longint c6, dt;
    c6 = longint'(cal_words[bptc_pkg::CFG_TEMP_SENS_COEF]);
    if (c6 == 0) begin
      dt = jitter;
    end else begin
      dt = ((target_centi - TEMP_REF_CENTI) * SCALE_2_23) / c6 + jitter;
    end
    return raw_word_t'(longint'(cal_words[bptc_pkg::CFG_REF_TEMPERATURE]) * SCALE_2_8 + dt);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic write_cal(input cfg_idx_t idx, input bptc_pkg::cal_t value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx < bptc_pkg::NUM_CAL) begin
      cal_words[idx] = value;
    end
  endtask

  task automatic queue_sample(input raw_word_t raw_p, input raw_word_t raw_t);
    sample_t s;
    s.raw_p = raw_p;
    s.raw_t = raw_t;
    pending_samples.push_back(s);
  endtask

  // block until every queued sample is through and its result is checked
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_samples.size() != 0 || in_bus.valid || expected_readings.size() != 0);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_TICKS);
    $display("timeout: %0d results still pending", expected_readings.size());
    $display("testbench: done, errors");
    $finish;
  end

  // sample driver, predicts each sample at its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid           <= 1'b0;
      in_bus.raw_pressure    <= '0;
      in_bus.raw_temperature <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_readings.push_back(compensate(in_bus.raw_pressure, in_bus.raw_temperature));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_sample = pending_samples.pop_front();
          in_bus.valid           <= 1'b1;
          in_bus.raw_pressure    <= next_sample.raw_p;
          in_bus.raw_temperature <= next_sample.raw_t;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected result temp %0d pres %0d clip %0b",
                                    out_bus.temperature_centi, out_bus.pressure_centi,
                                    out_bus.pressure_clipped));
        end else begin
          want = expected_readings.pop_front();
          checked_count++;
          if (want.clipped) clipped_count++;
          if (want.temp_centi < TEMP_REF_CENTI) cold_count++;
          if (want.temp_centi < VERY_LOW_CENTI) very_cold_count++;
          if (out_bus.temperature_centi !== want.temp_centi) begin
            report_mismatch($sformatf("temperature_centi %0d, want %0d",
                                      out_bus.temperature_centi, want.temp_centi));
          end
          if (out_bus.pressure_centi !== want.pres_centi) begin
            report_mismatch($sformatf("pressure_centi %0d, want %0d",
                                      out_bus.pressure_centi, want.pres_centi));
          end
          if (out_bus.pressure_clipped !== want.clipped) begin
            report_mismatch($sformatf("pressure_clipped %0b, want %0b",
                                      out_bus.pressure_clipped, want.clipped));
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    raw_word_t      d1_pick [3];
    raw_word_t      d2_pick [4];
    longint         temp_pick [3];
    raw_word_t      raw_p;
    raw_word_t      raw_t;
    bptc_pkg::cal_t value;
    idle_mode_e     mode;

    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    checked_count   = 0;
    clipped_count   = 0;
    cold_count      = 0;
    very_cold_count = 0;
    foreach (cal_words[i]) cal_words[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // calibration is all zero out of reset
    queue_sample(TYPICAL_D1, TYPICAL_D2);
    queue_sample('0, '0);
    queue_sample('1, '1);
    wait_idle();

    for (int r = 0; r < bptc_pkg::NUM_CAL; r++) write_cal(cfg_idx_t'(r), TYPICAL_CAL[r]);
    // writes to unused indexes must leave the calibration alone
    write_cal(CFG_UNUSED_LO, '1);
    write_cal(CFG_UNUSED_HI, bptc_pkg::cal_t'($urandom()));

    d1_pick = '{'0, '1, TYPICAL_D1};
    d2_pick = '{'0, '1,
                raw_word_t'(longint'(cal_words[bptc_pkg::CFG_REF_TEMPERATURE]) * SCALE_2_8),
                TYPICAL_D2};
    foreach (d1_pick[i]) begin
      foreach (d2_pick[j]) queue_sample(d1_pick[i], d2_pick[j]);
    end
    // either side of 20.00 C and of -15.00 C
    temp_pick = '{TEMP_REF_CENTI - 1, VERY_LOW_CENTI, VERY_LOW_CENTI - 1};
    foreach (temp_pick[i]) begin
      queue_sample(TYPICAL_D1, raw_temp_near(temp_pick[i], -1));
      queue_sample(TYPICAL_D1, raw_temp_near(temp_pick[i], 0));
    end
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (int r = 0; r < bptc_pkg::NUM_CAL; r++) begin
        case (phase)
          0: value = TYPICAL_CAL[r];
          1: value = '1;
          2: value = '0;
          default: begin
            case ($urandom_range(3))
              0: value = '0;
              1: value = '1;
              default: value = bptc_pkg::cal_t'($urandom());
            endcase
          end
        endcase
        write_cal(cfg_idx_t'(r), value);
      end
      write_cal($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                bptc_pkg::cal_t'($urandom()));

      mode = idle_mode_e'(phase % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        IDLE_SEND: begin
          send_idle_pct  = 66;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct  = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase

      for (int n = 0; n < SAMPLES_PER_SET; n++) begin
        // sender holds off mid-set until the pipeline has emptied
        if (n == SAMPLES_PER_SET / 2) wait_idle();
        case ($urandom_range(2))
          0: raw_p = raw_word_t'($urandom());
          1: raw_p = TYPICAL_D1 - 24'd1048576 + raw_word_t'($urandom_range(2097152));
          default: raw_p = $urandom_range(1) ? raw_word_t'($urandom_range(4095))
                                             : ~raw_word_t'($urandom_range(4095));
        endcase
        case ($urandom_range(3))
          0: raw_t = raw_word_t'($urandom());
          1: raw_t = raw_temp_near(TEMP_REF_CENTI, longint'($urandom_range(131072)) - 65536);
          2: raw_t = raw_temp_near(temp_pick[$urandom_range(2)],
                                   longint'($urandom_range(4)) - 2);
          default: raw_t = raw_word_t'($urandom_range(
                             {8'h00, cal_words[bptc_pkg::CFG_REF_TEMPERATURE], 8'h00}));
        endcase
        queue_sample(raw_p, raw_t);
      end
      wait_idle();
    end

    if (expected_readings.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
    end
    $display("summary: %0d results checked over %0d calibration sets, %0d saturated",
             checked_count, RANDOM_PHASES + 2, clipped_count);
    $display("summary: %0d below 20 C, %0d below -15 C, %0d mismatches",
             cold_count, very_cold_count, error_count);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
